@@ rtl/bitmap_range_engine_core_macros.svh @@
// ----------------------------------------------------------------------------
// Bitmap range engine assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_ENGINE_CORE_MACROS_SVH
`define BITMAP_RANGE_ENGINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bitmap range engine check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bitmap range engine check failed");

`endif

@@ rtl/bre_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap range engine package
// Shared constants, types and the byte mask helper.
// ----------------------------------------------------------------------------
package bre_pkg;

    // Default map size in bits.
    localparam int NUM_BITS_DEF = 4096;

    // Byte constants.
    localparam logic [7:0] FULL_BYTE = 8'hFF;

    // Request operations.
    typedef enum logic [2:0] {
        OP_TEST_ALL  = 3'd0,
        OP_TEST_ANY  = 3'd1,
        OP_SET_RANGE = 3'd2,
        OP_CLR_RANGE = 3'd3,
        OP_SET_ALL   = 3'd4,
        OP_CLR_ALL   = 3'd5
    } t_opcode;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_FILL,
        ST_RESP
    } t_state;

    // One result word.
    typedef struct packed {
        logic range_error;
        logic test_result;
    } t_result;

    // Memory port strobes.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_cmd;

    // Mask of bits lo..hi inclusive within one byte.
    function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [2:0] span;
        span = hi - lo;
        return (FULL_BYTE >> (3'd7 - span)) << lo;
    endfunction

endpackage

@@ rtl/bre_mem.sv @@
// ----------------------------------------------------------------------------
// Bitmap byte store
// One read port and one write port, read data registered.
// ----------------------------------------------------------------------------
module bre_mem #(
    parameter  int NUM_BITS = bre_pkg::NUM_BITS_DEF,
    localparam int MapBytes = (NUM_BITS + 7) / 8,
    localparam int AW       = (MapBytes > 1) ? $clog2(MapBytes) : 1
) (
    input  logic                 i_clk,
    input  bre_pkg::t_mem_cmd    i_cmd,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data,
    output logic [7:0]           o_rd_data
);

    logic [7:0] r_mem [0:MapBytes-1];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/bre_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap range engine sequencer
// Decodes requests, walks ranges byte by byte (read-only for tests, read-modify-write
// for set and clear), sweeps the whole map for fills and holds the result word.
// ----------------------------------------------------------------------------
module bre_ctrl #(
    parameter  int NUM_BITS = bre_pkg::NUM_BITS_DEF,
    localparam int MapBytes = (NUM_BITS + 7) / 8,
    localparam int AW       = (MapBytes > 1) ? $clog2(MapBytes) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request side
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_opcode,
    input  logic [11:0]          i_start_bit,
    input  logic [12:0]          i_range_length,
    // Result side
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bre_pkg::t_result     o_out_res,
    // Memory side
    output bre_pkg::t_mem_cmd    o_mem_cmd,
    output logic [AW-1:0]        o_rd_addr,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_wr_data,
    input  logic [7:0]           i_rd_data
);

    localparam logic [AW-1:0] LastAddr = AW'(MapBytes - 1);

    bre_pkg::t_state  r_state, n_state;
    bre_pkg::t_opcode r_op, n_op;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_first, n_first;
    logic [AW-1:0]    r_last, n_last;
    logic [2:0]       r_lo, n_lo;
    logic [2:0]       r_hi, n_hi;
    logic             r_issue_done, n_issue_done;
    logic             r_p_valid, n_p_valid;
    logic [AW-1:0]    r_p_addr, n_p_addr;
    logic             r_p_first, n_p_first;
    logic             r_p_last, n_p_last;
    logic             r_all, n_all;
    logic             r_any, n_any;
    logic             r_fill, n_fill;
    bre_pkg::t_result r_res, n_res;
    logic             r_out_valid, n_out_valid;
    bre_pkg::t_result r_out_res, n_out_res;

    // Request decode helpers.
    logic [13:0] req_sum;
    logic [13:0] req_end;
    logic [31:0] req_first_w;
    logic [31:0] req_last_w;
    logic        req_err;
    logic        req_empty;

    assign req_sum     = {2'b00, i_start_bit} + {1'b0, i_range_length};
    assign req_end     = req_sum - 14'd1;
    assign req_first_w = 32'(i_start_bit[11:3]);
    assign req_last_w  = 32'(req_end[13:3]);
    assign req_err     = 32'(req_sum) > 32'(NUM_BITS);
    assign req_empty   = (i_range_length == 13'd0);

    // Byte currently returned from memory, masked to the range.
    logic [2:0] cur_lo;
    logic [2:0] cur_hi;
    logic [7:0] cur_mask;
    logic [7:0] cur_hit;

    assign cur_lo   = r_p_first ? r_lo : 3'd0;
    assign cur_hi   = r_p_last ? r_hi : 3'd7;
    assign cur_mask = bre_pkg::span_mask(cur_lo, cur_hi);
    assign cur_hit  = i_rd_data & cur_mask;

    assign o_in_ready = (r_state == bre_pkg::ST_IDLE);

    // Next state, memory strobes and datapath updates.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_addr       = r_addr;
        n_first      = r_first;
        n_last       = r_last;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_issue_done = r_issue_done;
        n_p_valid    = 1'b0;
        n_p_addr     = r_p_addr;
        n_p_first    = r_p_first;
        n_p_last     = r_p_last;
        n_all        = r_all;
        n_any        = r_any;
        n_fill       = r_fill;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_res    = r_out_res;
        o_mem_cmd    = '0;
        o_rd_addr    = r_addr;
        o_wr_addr    = r_p_addr;
        o_wr_data    = i_rd_data;

        unique case (r_state)
            bre_pkg::ST_CLEAR: begin
                // Clearing pass after reset.
                o_mem_cmd.wr_en = 1'b1;
                o_wr_addr       = r_addr;
                o_wr_data       = 8'h00;
                if (r_addr == LastAddr) begin
                    n_state = bre_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            bre_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op         = bre_pkg::t_opcode'(i_opcode);
                    n_res        = '0;
                    n_addr       = req_first_w[AW-1:0];
                    n_first      = req_first_w[AW-1:0];
                    n_last       = req_last_w[AW-1:0];
                    n_lo         = i_start_bit[2:0];
                    n_hi         = req_end[2:0];
                    n_issue_done = 1'b0;
                    n_all        = 1'b1;
                    n_any        = 1'b0;
                    unique case (i_opcode) inside
                        bre_pkg::OP_TEST_ALL, bre_pkg::OP_TEST_ANY,
                        bre_pkg::OP_SET_RANGE, bre_pkg::OP_CLR_RANGE: begin
                            if (req_err) begin
                                n_res.range_error = 1'b1;
                                n_state           = bre_pkg::ST_RESP;
                            end else if (req_empty) begin
                                n_res.test_result = (i_opcode == bre_pkg::OP_TEST_ALL);
                                n_state           = bre_pkg::ST_RESP;
                            end else begin
                                n_state = bre_pkg::ST_WALK;
                            end
                        end
                        bre_pkg::OP_SET_ALL, bre_pkg::OP_CLR_ALL: begin
                            n_addr  = '0;
                            n_fill  = (i_opcode == bre_pkg::OP_SET_ALL);
                            n_state = bre_pkg::ST_FILL;
                        end
                        default: begin
                            n_state = bre_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            bre_pkg::ST_WALK: begin
                // Issue side: one byte read per cycle up to the last byte.
                if (!r_issue_done) begin
                    o_mem_cmd.rd_en = 1'b1;
                    n_p_valid       = 1'b1;
                    n_p_addr        = r_addr;
                    n_p_first       = (r_addr == r_first);
                    n_p_last        = (r_addr == r_last);
                    if (r_addr == r_last) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // Return side: test or modify the byte read last cycle.
                if (r_p_valid) begin
                    unique case (r_op)
                        bre_pkg::OP_TEST_ALL: begin
                            if (cur_hit != cur_mask) begin
                                n_all = 1'b0;
                            end
                        end
                        bre_pkg::OP_TEST_ANY: begin
                            if (cur_hit != 8'h00) begin
                                n_any = 1'b1;
                            end
                        end
                        bre_pkg::OP_SET_RANGE: begin
                            o_mem_cmd.wr_en = 1'b1;
                            o_wr_data       = i_rd_data | cur_mask;
                        end
                        default: begin
                            o_mem_cmd.wr_en = 1'b1;
                            o_wr_data       = i_rd_data & ~cur_mask;
                        end
                    endcase
                    if (r_p_last) begin
                        n_res.range_error = 1'b0;
                        n_res.test_result = (r_op == bre_pkg::OP_TEST_ALL) ? n_all :
                                            (r_op == bre_pkg::OP_TEST_ANY) ? n_any : 1'b0;
                        n_state           = bre_pkg::ST_RESP;
                    end
                end
            end

            bre_pkg::ST_FILL: begin
                // Whole-map fill, one byte per cycle.
                o_mem_cmd.wr_en = 1'b1;
                o_wr_addr       = r_addr;
                o_wr_data       = {8{r_fill}};
                if (r_addr == LastAddr) begin
                    n_state = bre_pkg::ST_RESP;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end

            bre_pkg::ST_RESP: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_state     = bre_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bre_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bre_pkg::ST_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_p_valid    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_p_valid    <= n_p_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_first   <= n_first;
        r_last    <= n_last;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_p_addr  <= n_p_addr;
        r_p_first <= n_p_first;
        r_p_last  <= n_p_last;
        r_all     <= n_all;
        r_any     <= n_any;
        r_fill    <= n_fill;
        r_res     <= n_res;
        r_out_res <= n_out_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

@@ rtl/bitmap_range_engine_core.sv @@
// ----------------------------------------------------------------------------
// Bitmap range engine
// Byte-organized status bitmap with range test, set and clear requests.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word fields (lowest bit first)
//  s (req)   in   opcode[2:0], start_bit[14:3], range_length[27:15]
//  m (rsp)   out  test_result[0], range_error[1]
//
//  For a range request the walk reads one byte per cycle through the single
//  memory and, for set and clear, writes each byte back. Set-all and
//  clear-all sweep every byte. After reset a clearing pass over every byte
//  runs; no request is taken until it ends. A finished result waits in an
//  output register, so a stalled result side blocks only once the next
//  result is ready.
// ----------------------------------------------------------------------------
module bitmap_range_engine_core #(
    parameter int NUM_BITS = bre_pkg::NUM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // opcode, start_bit, range_length, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // test_result, range_error, zero pad
);

    localparam int MapBytes = (NUM_BITS + 7) / 8;
    localparam int AW       = (MapBytes > 1) ? $clog2(MapBytes) : 1;

    bre_pkg::t_mem_cmd mem_cmd;
    bre_pkg::t_result  out_res;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    // Sequencer.
    bre_ctrl #(
        .NUM_BITS (NUM_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_tvalid),
        .o_in_ready     (o_s_tready),
        .i_opcode       (i_s_tdata[2:0]),
        .i_start_bit    (i_s_tdata[14:3]),
        .i_range_length (i_s_tdata[27:15]),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_out_res      (out_res),
        .o_mem_cmd      (mem_cmd),
        .o_rd_addr      (rd_addr),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .i_rd_data      (rd_data)
    );

    // Bitmap storage.
    bre_mem #(
        .NUM_BITS (NUM_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Result word packing.
    assign o_m_tdata = {6'b000000, out_res.range_error, out_res.test_result};

endmodule

@@ rtl/bre_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap range engine port checker
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`include "bitmap_range_engine_core_macros.svh"

module bre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata
);

    // A result word that is not taken stays offered.
    `BRE_ASSERT_NEXT(a_rsp_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // A stalled result word keeps its value.
    `BRE_ASSERT_NEXT(a_rsp_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))

    // An error result never carries a test answer, and padding stays zero.
    `BRE_ASSERT_SAME(a_rsp_legal, o_m_tvalid, !(o_m_tdata[0] && o_m_tdata[1]) && (o_m_tdata[7:2] == 6'd0))

    // A request keeps the engine busy for at least the following cycle.
    `BRE_ASSERT_NEXT(a_req_busy, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind bitmap_range_engine_core bre_checker u_bre_checker (.*);
